// ===== rtl/mstq_pkg.sv =====
package mstq_pkg;

    // Tree geometry and fixed field widths
    localparam int LEAVES_DEFAULT = 1024;
    localparam int IDX_W          = 10;
    localparam int SIZE_W         = 11;
    localparam logic [SIZE_W-1:0] USED_SIZE_RESET = 11'd1024;

    // Request function codes
    typedef enum logic {
        FUNC_SET   = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // Input request
    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
        logic              mark;
    } t_in_req;

    // Query result
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  min_position;
    } t_out_res;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_LEAF,
        S_SET_UP,
        S_Q_A,
        S_Q_B,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load;
        logic set_leaf;
        logic set_up;
        logic q_a;
        logic q_b;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic in_query;
        logic in_ok;
        logic root;
        logic range_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/min_segment_tree_mark_query.sv =====
// Set request: one node written per cycle on the leaf-to-root path, from the leaf up to the
//   root, before ready returns. Dropped set: ready again next cycle.
// Query request: result and ready follow a walk with two node reads per level, plus any
//   wait for the previous result to leave the output; an out-of-range query skips the walk.
// One request in flight. Reset (synchronous, active low) sweeps all 2*LEAVES nodes to
//   empty with no request taken; config writes are taken meanwhile.
module min_segment_tree_mark_query #(
    parameter int LEAVES = mstq_pkg::LEAVES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mstq_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  mstq_pkg::t_in_req            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output mstq_pkg::t_out_res           o_out_data
);

    mstq_pkg::t_cmd  cmd;
    mstq_pkg::t_stat stat;

    mstq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    mstq_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // No request is taken right after reset while nodes are being cleared
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request ready during node clearing");

    // An accepted query always takes the block out of the idle state, so ready drops
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.func == mstq_pkg::FUNC_QUERY)
        |=> !o_in_ready)
        else $error("ready right after query accept");

    // A not-found result carries a zero position
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.min_position == '0))
        else $error("not-found result with nonzero position");

endmodule

// ===== rtl/mstq_ctrl.sv =====
module mstq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mstq_pkg::t_stat i_stat,
    output mstq_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);

    mstq_pkg::t_state r_state;
    mstq_pkg::t_state n_state;

    // State register; reset starts the node clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mstq_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mstq_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = mstq_pkg::S_IDLE;
            end
            mstq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_query) begin
                        n_state = i_stat.in_ok ? mstq_pkg::S_Q_A : mstq_pkg::S_EMIT;
                    end else if (i_stat.in_ok) begin
                        n_state = mstq_pkg::S_SET_LEAF;
                    end
                end
            end
            mstq_pkg::S_SET_LEAF: n_state = mstq_pkg::S_SET_UP;
            mstq_pkg::S_SET_UP: begin
                if (i_stat.root) n_state = mstq_pkg::S_IDLE;
            end
            mstq_pkg::S_Q_A: begin
                n_state = i_stat.range_done ? mstq_pkg::S_EMIT : mstq_pkg::S_Q_B;
            end
            mstq_pkg::S_Q_B: n_state = mstq_pkg::S_Q_A;
            mstq_pkg::S_EMIT: begin
                if (i_stat.out_free) n_state = mstq_pkg::S_IDLE;
            end
            default: n_state = mstq_pkg::S_CLEAR;
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mstq_pkg::S_CLEAR:    o_cmd.clr = 1'b1;
            mstq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mstq_pkg::S_SET_LEAF: o_cmd.set_leaf = 1'b1;
            mstq_pkg::S_SET_UP:   o_cmd.set_up = 1'b1;
            mstq_pkg::S_Q_A:      o_cmd.q_a = 1'b1;
            mstq_pkg::S_Q_B:      o_cmd.q_b = 1'b1;
            mstq_pkg::S_EMIT:     o_cmd.emit = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/mstq_dpath.sv =====
module mstq_dpath #(
    parameter int LEAVES = mstq_pkg::LEAVES_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mstq_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  mstq_pkg::t_in_req            i_in_data,
    input  logic                         i_out_ready,
    input  mstq_pkg::t_cmd               i_cmd,
    output mstq_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output mstq_pkg::t_out_res           o_out_data
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int RW    = $clog2(NODES + 1);
    localparam int VW    = $clog2(LEAVES + 1);
    localparam logic [VW-1:0] SENT = VW'(LEAVES);

    // Node minimum store
    logic [VW-1:0] r_mem [0:NODES-1];
    logic [VW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Control and working registers
    logic [mstq_pkg::SIZE_W-1:0] r_used_size;
    logic [AW-1:0]               r_clr_cnt;
    logic [AW-1:0]               r_k,      n_k;
    logic [VW-1:0]               r_cur,    n_cur;
    logic [RW-1:0]               r_l,      n_l;
    logic [RW-1:0]               r_r,      n_r;
    logic [VW-1:0]               r_best,   n_best;
    logic                        r_pend_l, n_pend_l;
    logic                        r_pend_r, n_pend_r;
    logic                        r_out_valid;
    mstq_pkg::t_out_res          r_out_data;

    logic [31:0]   eff_size;
    logic [AW-1:0] k_up;
    logic [VW-1:0] up_min;
    logic [VW-1:0] acc_min;
    logic          found;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // Request checks against the effective size
    assign eff_size = (32'(r_used_size) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(r_used_size);
    assign o_stat.in_query = (i_in_data.func == mstq_pkg::FUNC_QUERY);
    assign o_stat.in_ok    = (i_in_data.func == mstq_pkg::FUNC_QUERY)
                           ? ((i_in_data.first_index <= i_in_data.last_index)
                              && (32'(i_in_data.last_index) < eff_size))
                           : (32'(i_in_data.first_index) < eff_size);

    // Update and query path helpers
    assign k_up    = r_k >> 1;
    assign up_min  = (r_rdata < r_cur) ? r_rdata : r_cur;
    assign acc_min = (r_rdata < r_best) ? r_rdata : r_best;
    assign found   = (r_best != SENT);

    assign o_stat.clr_last   = (r_clr_cnt == AW'(NODES - 1));
    assign o_stat.root       = (k_up == AW'(1));
    assign o_stat.range_done = (r_l >= r_r);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = SENT;
        mem_raddr = '0;
        if (i_cmd.clr) begin
            mem_we = 1'b1;
        end else if (i_cmd.set_leaf) begin
            mem_we    = 1'b1;
            mem_waddr = r_k;
            mem_wdata = r_cur;
            mem_raddr = r_k ^ AW'(1);
        end else if (i_cmd.set_up) begin
            mem_we    = 1'b1;
            mem_waddr = k_up;
            mem_wdata = up_min;
            mem_raddr = k_up ^ AW'(1);
        end else if (i_cmd.q_a) begin
            mem_raddr = r_l[AW-1:0];
        end else if (i_cmd.q_b) begin
            mem_raddr = AW'(r_r - RW'(1));
        end
    end

    // Working register next values
    always_comb begin
        n_k      = r_k;
        n_cur    = r_cur;
        n_l      = r_l;
        n_r      = r_r;
        n_best   = r_best;
        n_pend_l = r_pend_l;
        n_pend_r = r_pend_r;
        if (i_cmd.load) begin
            n_k      = AW'(i_in_data.first_index) + AW'(LEAVES);
            n_cur    = i_in_data.mark ? VW'(i_in_data.first_index) : SENT;
            n_l      = RW'(i_in_data.first_index) + RW'(LEAVES);
            n_r      = RW'(i_in_data.last_index) + RW'(LEAVES) + RW'(1);
            n_best   = SENT;
            n_pend_l = 1'b0;
            n_pend_r = 1'b0;
        end else if (i_cmd.set_up) begin
            n_k   = k_up;
            n_cur = up_min;
        end else if (i_cmd.q_a) begin
            // fold the right node read in the previous step, then take left edge
            if (r_pend_r) n_best = acc_min;
            n_pend_r = 1'b0;
            n_pend_l = r_l[0];
            if (r_l[0]) n_l = r_l + RW'(1);
        end else if (i_cmd.q_b) begin
            // fold the left node, take right edge, climb one level
            if (r_pend_l) n_best = acc_min;
            n_pend_l = 1'b0;
            n_pend_r = r_r[0];
            n_r      = (r_r - RW'(r_r[0])) >> 1;
            n_l      = r_l >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_cur  <= n_cur;
        r_l    <= n_l;
        r_r    <= n_r;
        r_best <= n_best;
    end

    // Control registers, config register and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_size <= mstq_pkg::USED_SIZE_RESET;
            r_clr_cnt   <= '0;
            r_pend_l    <= 1'b0;
            r_pend_r    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_used_size <= i_cfg_wdata;
            if (i_cmd.clr) r_clr_cnt <= r_clr_cnt + AW'(1);
            r_pend_l <= n_pend_l;
            r_pend_r <= n_pend_r;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.found        <= found;
            r_out_data.min_position <= found ? mstq_pkg::IDX_W'(r_best) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== bench/tb_min_segment_tree_mark_query.sv =====
`timescale 1ns / 1ps

module tb_min_segment_tree_mark_query;

    localparam int LEAVES        = mstq_pkg::LEAVES_DEFAULT;
    localparam int SETTLE_CYCLES = 40;    // longer than one query walk
    localparam int PHASE_ITEMS   = 60;
    localparam int MAX_REPORTS   = 10;

    // Prediction of the tree: one mark bit per position, plus the used size
    class mark_scoreboard;
        bit                           marks [LEAVES];
        logic [mstq_pkg::SIZE_W-1:0]  used_size;
        mstq_pkg::t_out_res           expected_minima [$];
        int unsigned                  errors;

        function new();
            foreach (marks[p]) marks[p] = 1'b0;
            used_size = mstq_pkg::USED_SIZE_RESET;
            errors    = 0;
        endfunction

        function void set_used_size(logic [mstq_pkg::SIZE_W-1:0] value);
            used_size = value;
        endfunction

        function int unsigned outstanding();
            return expected_minima.size();
        endfunction

        // Apply one accepted request; queries queue their expected minimum
        function void take_request(mstq_pkg::t_in_req req);
            int unsigned        size;
            int unsigned        p;
            mstq_pkg::t_out_res res;
            size = (used_size > LEAVES) ? LEAVES : 32'(used_size);
            if (req.func == mstq_pkg::FUNC_SET) begin
                if (req.first_index < size) marks[req.first_index] = req.mark;
            end else begin
                res = '0;
                if (req.first_index <= req.last_index && req.last_index < size) begin
                    for (p = 32'(req.first_index); p <= req.last_index; p++) begin
                        if (marks[p]) begin
                            res.found        = 1'b1;
                            res.min_position = p[mstq_pkg::IDX_W-1:0];
                            break;
                        end
                    end
                end
                expected_minima.insert(expected_minima.size(), res);
            end
        endfunction

        // Compare a delivered result with the oldest expected minimum
        function void match_result(mstq_pkg::t_out_res got);
            mstq_pkg::t_out_res want;
            if (expected_minima.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: found=%0d min_position=%0d",
                             got.found, got.min_position);
                return;
            end
            want = expected_minima.pop_front();
            if (got.found !== want.found || got.min_position !== want.min_position) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected %0d/%0d, got %0d/%0d (found/min_position)",
                             want.found, want.min_position, got.found, got.min_position);
            end
        endfunction
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [mstq_pkg::SIZE_W-1:0]  i_cfg_wdata = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_ready;
    mstq_pkg::t_in_req            i_in_data   = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    mstq_pkg::t_out_res           o_out_data;

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    mark_scoreboard     sb = new();

    min_segment_tree_mark_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.match_result(o_out_data);
    end

    function automatic mstq_pkg::t_in_req make_request(mstq_pkg::t_func func, int first,
                                                       int last, bit mark);
        mstq_pkg::t_in_req req;
        req.func        = func;
        req.first_index = first[mstq_pkg::IDX_W-1:0];
        req.last_index  = last[mstq_pkg::IDX_W-1:0];
        req.mark        = mark;
        return req;
    endfunction

    // Mostly in-range sets and queries, some raw noise
    function automatic mstq_pkg::t_in_req draw_request(int unsigned eff);
        mstq_pkg::t_in_req req;
        int      hi_lim;
        int      f;
        int      l;
        int      pick;
        hi_lim          = (eff == 0) ? 0 : int'(eff) - 1;
        req.mark        = ($urandom_range(99) < 65);
        req.last_index  = mstq_pkg::IDX_W'($urandom_range(LEAVES - 1));
        req.first_index = mstq_pkg::IDX_W'($urandom_range(LEAVES - 1));
        if ($urandom_range(99) < 10) begin
            req.func = mstq_pkg::t_func'($urandom_range(1));
        end else if ($urandom_range(99) < 45) begin
            req.func        = mstq_pkg::FUNC_SET;
            req.first_index = mstq_pkg::IDX_W'($urandom_range(hi_lim));
        end else begin
            req.func = mstq_pkg::FUNC_QUERY;
            f        = int'($urandom_range(hi_lim));
            pick     = int'($urandom_range(2));
            if (pick == 0)
                l = int'($urandom_range(hi_lim, f));
            else if (pick == 1)
                l = f + int'($urandom_range((hi_lim - f < 15) ? hi_lim - f : 15));
            else
                l = f + int'($urandom_range((hi_lim - f < 127) ? hi_lim - f : 127));
            req.first_index = f[mstq_pkg::IDX_W-1:0];
            req.last_index  = l[mstq_pkg::IDX_W-1:0];
        end
        return req;
    endfunction

    // Offer one request; returns at the edge where it is accepted
    task automatic send_request(mstq_pkg::t_in_req req);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_request(req);
    endtask

    // Hold off requests until every result is in and the block has gone quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_used_size(logic [mstq_pkg::SIZE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_used_size(value);
    endtask

    initial begin
        int          ph;
        int          n;
        int unsigned eff;
        logic [mstq_pkg::SIZE_W-1:0] size_val;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tree, ends of the range, reversed ranges, set and clear
        send_idle_pct = 15;
        recv_idle_pct = 71;
        write_used_size(mstq_pkg::USED_SIZE_RESET);
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 0, 0, 1));
        send_request(make_request(mstq_pkg::FUNC_SET, 1023, 0, 1));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1, 1022, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1023, 1023, 1));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 5, 3, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1023, 0, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 512, 1023, 1));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1, 1023, 1));
        send_request(make_request(mstq_pkg::FUNC_SET, 0, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 1023, 0, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 513, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 1022, 0, 1));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 0, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1022, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 512, 0, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 1023, 0));
        send_request(make_request(mstq_pkg::FUNC_SET, 1, 0, 1));
        send_request(make_request(mstq_pkg::FUNC_SET, 1, 0, 1));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 1, 1, 0));
        send_request(make_request(mstq_pkg::FUNC_QUERY, 0, 1, 0));

        // Random phases, each under a chosen used size and idle mix
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       size_val = 11'd1024;
                1:       size_val = 11'd16;
                2:       size_val = 11'd2047;
                3:       size_val = 11'd300;
                4:       size_val = 11'd1;
                5:       size_val = 11'd0;
                default: size_val = 11'd1024;
            endcase
            if (ph < 2) begin
                send_idle_pct = 15;
                recv_idle_pct = 71;
            end else if (ph < 4) begin
                send_idle_pct = 71;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_used_size(size_val);
            eff = (size_val > LEAVES) ? LEAVES : 32'(size_val);
            for (n = 0; n < PHASE_ITEMS; n++) send_request(draw_request(eff));
        end
        wait_idle();

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("min_segment_tree_mark_query test passed");
        end else begin
            $display("min_segment_tree_mark_query test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("min_segment_tree_mark_query test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mstq_pkg.sv
rtl/mstq_ctrl.sv
rtl/mstq_dpath.sv
rtl/min_segment_tree_mark_query.sv
bench/tb_min_segment_tree_mark_query.sv
